@@ rtl/core/itora_pkg.sv @@
// Shared constants, types, microcode and digit table for the radix ASCII converter.
package itora_pkg;

    localparam int WORD_BITS     = 32;
    localparam int MAX_DIGITS    = 32;
    localparam int RADIX_W       = 5;
    localparam int DIGIT_W       = 4;
    localparam int CHAR_W        = 8;
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS     = WORD_BITS / BITS_PER_STEP;
    localparam int STEP_CNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W         = $clog2(MAX_DIGITS);
    localparam int REM_W         = RADIX_W;
    localparam int IN_DATA_W     = ((WORD_BITS + RADIX_W + 7) / 8) * 8;
    localparam int PC_W          = 3;

    localparam logic [RADIX_W-1:0] BASE_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] BASE_MAX = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] BASE_TEN = RADIX_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_DIV   = 3'd1,
        OP_STORE = 3'd2,
        OP_SIGN  = 3'd3,
        OP_ISSUE = 3'd4,
        OP_EMIT  = 3'd5,
        OP_NOP   = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        COND_NEVER     = 4'd0,
        COND_ALWAYS    = 4'd1,
        COND_NO_IN     = 4'd2,
        COND_DIV_MORE  = 4'd3,
        COND_QUOT_NZ   = 4'd4,
        COND_SIGN_WAIT = 4'd5,
        COND_EMPTY     = 4'd6,
        COND_OUT_BUSY  = 4'd7,
        COND_MORE      = 4'd8
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           hold;
        t_cond           jump;
        logic [PC_W-1:0] target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DIV   = PC_W'(1);
    localparam logic [PC_W-1:0] PC_STORE = PC_W'(2);
    localparam logic [PC_W-1:0] PC_SIGN  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_ISSUE = PC_W'(4);
    localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(5);
    localparam logic [PC_W-1:0] PC_END   = PC_W'(6);

    function automatic t_uword microcode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_LOAD:  w = '{OP_LOAD,  COND_NO_IN,     COND_NEVER,   PC_LOAD};
            PC_DIV:   w = '{OP_DIV,   COND_DIV_MORE,  COND_NEVER,   PC_DIV};
            PC_STORE: w = '{OP_STORE, COND_NEVER,     COND_QUOT_NZ, PC_DIV};
            PC_SIGN:  w = '{OP_SIGN,  COND_SIGN_WAIT, COND_NEVER,   PC_SIGN};
            PC_ISSUE: w = '{OP_ISSUE, COND_NEVER,     COND_EMPTY,   PC_LOAD};
            PC_EMIT:  w = '{OP_EMIT,  COND_OUT_BUSY,  COND_MORE,    PC_ISSUE};
            PC_END:   w = '{OP_NOP,   COND_NEVER,     COND_ALWAYS,  PC_LOAD};
            default:  w = '{OP_NOP,   COND_NEVER,     COND_ALWAYS,  PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/itora_div_step.sv @@
// Restoring division by the base over four quotient bits of the shifted word.
module itora_div_step (
    input  logic [itora_pkg::WORD_BITS-1:0] i_value,
    input  logic [itora_pkg::REM_W-1:0]     i_rem,
    input  logic [itora_pkg::RADIX_W-1:0]   i_base,
    output logic [itora_pkg::WORD_BITS-1:0] o_value,
    output logic [itora_pkg::REM_W-1:0]     o_rem
);
    import itora_pkg::*;

    always_comb begin
        logic [WORD_BITS-1:0] v;
        logic [REM_W-1:0]     r;
        v = i_value;
        r = i_rem;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            r = {r[REM_W-2:0], v[WORD_BITS-1]};
            v = {v[WORD_BITS-2:0], 1'b0};
            if (r >= i_base) begin
                r    = r - i_base;
                v[0] = 1'b1;
            end
        end
        o_value = v;
        o_rem   = r;
    end

endmodule

@@ rtl/core/integer_to_radix_ascii_unit.sv @@
// Top level: microcoded conversion of a word into ASCII digits in base 2 to 16.
// One item in gives one character per digit, most significant first, with a leading
// '-' for a negative word in base ten and tlast on the final character. A small
// microprogram drives the datapath: each digit takes 8 division steps of four
// quotient bits and then a store, and each character takes a digit store read and
// then a write into the output register; the write waits while the output stalls.
// After the last character enters the output register, the microprogram passes
// through an end state and returns to load, where the next item is taken.
module integer_to_radix_ascii_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [itora_pkg::IN_DATA_W-1:0]    i_s_tdata,   // value, radix, zero pad
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [itora_pkg::CHAR_W-1:0]       o_m_tdata,   // ascii_char
    output logic                               o_m_tlast
);
    import itora_pkg::*;

    logic [PC_W-1:0]       r_pc, n_pc;
    logic [WORD_BITS-1:0]  r_value;
    logic [REM_W-1:0]      r_rem;
    logic [RADIX_W-1:0]    r_base;
    logic                  r_neg;
    logic [STEP_CNT_W-1:0] r_step;
    logic [CNT_W-1:0]      r_count;
    logic [DIGIT_W-1:0]    r_store [MAX_DIGITS];
    logic [DIGIT_W-1:0]    r_rd_digit;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;

    t_uword                uw;
    logic                  out_free;
    logic                  hold_c, jump_c;
    logic                  in_acc;
    logic [WORD_BITS-1:0]  in_value;
    logic [RADIX_W-1:0]    in_radix, in_base;
    logic                  in_neg;
    logic [WORD_BITS-1:0]  div_value;
    logic [REM_W-1:0]      div_rem;
    logic [CNT_W-1:0]      cap;
    logic                  emit_sign, emit_digit;

    function automatic logic eval_cond(input t_cond c, input logic no_in,
                                       input logic div_more, input logic quot_nz,
                                       input logic sign_wait, input logic empty,
                                       input logic busy, input logic more);
        logic res;
        unique case (c)
            COND_NEVER:     res = 1'b0;
            COND_ALWAYS:    res = 1'b1;
            COND_NO_IN:     res = no_in;
            COND_DIV_MORE:  res = div_more;
            COND_QUOT_NZ:   res = quot_nz;
            COND_SIGN_WAIT: res = sign_wait;
            COND_EMPTY:     res = empty;
            COND_OUT_BUSY:  res = busy;
            COND_MORE:      res = more;
            default:        res = 1'b0;
        endcase
        return res;
    endfunction

    itora_div_step u_div_step (
        .i_value (r_value),
        .i_rem   (r_rem),
        .i_base  (r_base),
        .o_value (div_value),
        .o_rem   (div_rem)
    );

    assign uw         = microcode(r_pc);
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (uw.op == OP_LOAD);
    assign in_acc     = i_s_tvalid && o_s_tready;

    assign in_value = i_s_tdata[WORD_BITS-1:0];
    assign in_radix = i_s_tdata[WORD_BITS+RADIX_W-1:WORD_BITS];

    always_comb begin
        priority if (in_radix < BASE_MIN) begin
            in_base = BASE_MIN;
        end else if (in_radix > BASE_MAX) begin
            in_base = BASE_MAX;
        end else begin
            in_base = in_radix;
        end
    end

    assign in_neg     = (in_base == BASE_TEN) && in_value[WORD_BITS-1];
    assign cap        = r_neg ? CNT_W'(MAX_DIGITS - 1) : CNT_W'(MAX_DIGITS);
    assign emit_sign  = (uw.op == OP_SIGN) && r_neg && out_free;
    assign emit_digit = (uw.op == OP_EMIT) && out_free;

    always_comb begin
        hold_c = eval_cond(uw.hold, !i_s_tvalid, r_step != STEP_CNT_W'(DIV_STEPS - 1),
                           r_value != '0, r_neg && !out_free, r_count == '0,
                           !out_free, r_count != CNT_W'(1));
        jump_c = eval_cond(uw.jump, !i_s_tvalid, r_step != STEP_CNT_W'(DIV_STEPS - 1),
                           r_value != '0, r_neg && !out_free, r_count == '0,
                           !out_free, r_count != CNT_W'(1));
        priority if (hold_c) begin
            n_pc = r_pc;
        end else if (jump_c) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_LOAD;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_value     <= '0;
        end else begin
            r_pc <= n_pc;
            if (emit_sign || emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (uw.op)
                OP_LOAD: begin
                    if (in_acc) begin
                        r_value <= in_neg ? (WORD_BITS'(0) - in_value) : in_value;
                        r_count <= '0;
                    end
                end
                OP_DIV: begin
                    r_value <= div_value;
                end
                OP_STORE: begin
                    if (r_count < cap) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_EMIT: begin
                    if (out_free) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                OP_SIGN, OP_ISSUE, OP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == OP_LOAD && in_acc) begin
            r_base <= in_base;
            r_neg  <= in_neg;
            r_rem  <= '0;
            r_step <= '0;
        end else if (uw.op == OP_DIV) begin
            r_rem  <= div_rem;
            r_step <= r_step + STEP_CNT_W'(1);
        end else if (uw.op == OP_STORE) begin
            r_rem  <= '0;
            r_step <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == OP_STORE && r_count < cap) begin
            r_store[r_count[IDX_W-1:0]] <= r_rem[DIGIT_W-1:0];
        end
        if (uw.op == OP_ISSUE) begin
            r_rd_digit <= r_store[IDX_W'(r_count - CNT_W'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= (r_count == '0);
        end else if (emit_digit) begin
            r_out_char <= DIGIT_CHARS[r_rd_digit];
            r_out_last <= (r_count == CNT_W'(1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule
